@@ sv/cell_fault_scan_monitor_defines.svh @@
// Assertion macros for the cell fault scan monitor RTL.
`ifndef CELL_FAULT_SCAN_MONITOR_DEFINES_SVH
`define CELL_FAULT_SCAN_MONITOR_DEFINES_SVH

// Check a consequence in the same cycle as its condition.
`define CFSM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cell fault scan monitor: check failed");

// Check a consequence in the cycle after its condition.
`define CFSM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cell fault scan monitor: check failed");

`endif

@@ sv/cfsm_pkg.sv @@
// Shared types, constants and register codes for the cell fault scan monitor.
package cfsm_pkg;

    // Default sizes
    localparam int CELLS_PER_SCAN_DEF = 96;
    localparam int MAX_BOARDS_DEF     = 16;

    // Field widths
    localparam int VOLT_W  = 16;
    localparam int CPB_W   = 4;
    localparam int ISL_W   = 5;
    localparam int CELL_W  = 7;
    localparam int FLAG_W  = 8;
    localparam int COUNT_W = 9;
    localparam int IN_W    = 24;
    localparam int OUT_W   = 48;

    // Configuration port
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;
    localparam int REG_IW  = 2;

    localparam logic [REG_IW-1:0] REG_OV_THR = 2'd0;
    localparam logic [REG_IW-1:0] REG_UV_THR = 2'd1;
    localparam logic [REG_IW-1:0] REG_CPB    = 2'd2;
    localparam logic [REG_IW-1:0] REG_ISL    = 2'd3;

    localparam logic [VOLT_W-1:0] OV_THR_RST = 16'd42000;
    localparam logic [VOLT_W-1:0] UV_THR_RST = 16'd30000;
    localparam logic [CPB_W-1:0]  CPB_RST    = 4'd8;
    localparam logic [ISL_W-1:0]  ISL_RST    = 5'd3;

    // Fault byte bits
    localparam logic [FLAG_W-1:0] FLAG_OV         = 8'h01;
    localparam logic [FLAG_W-1:0] FLAG_UV         = 8'h02;
    localparam logic [FLAG_W-1:0] FLAG_OT         = 8'h04;
    localparam logic [FLAG_W-1:0] FLAG_TEMP_OPEN  = 8'h10;
    localparam logic [FLAG_W-1:0] FLAG_BOARD_COMM = 8'h20;
    localparam logic [FLAG_W-1:0] FLAG_CELL_OPEN  = 8'h80;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;

    typedef struct packed {
        logic [VOLT_W-1:0] ov_thr;
        logic [VOLT_W-1:0] uv_thr;
        logic [CPB_W-1:0]  cpb;
        logic [ISL_W-1:0]  isl;
    } cfg_t;

endpackage

@@ sv/cfsm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module cfsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read; hold the last data when not reading
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ sv/cfsm_cfg.sv @@
// Configuration registers behind the APB-style port.
module cfsm_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cfsm_pkg::APB_AW-1:0] paddr,
    input  logic [cfsm_pkg::APB_DW-1:0] pwdata,
    output logic [cfsm_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    output cfsm_pkg::cfg_t              cfg
);

    logic [cfsm_pkg::VOLT_W-1:0] ov_thr_reg;
    logic [cfsm_pkg::VOLT_W-1:0] uv_thr_reg;
    logic [cfsm_pkg::CPB_W-1:0]  cpb_reg;
    logic [cfsm_pkg::ISL_W-1:0]  isl_reg;
    logic [cfsm_pkg::REG_IW-1:0] reg_idx;
    logic                        wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[cfsm_pkg::REG_IW+1:2];
    assign wr_en   = psel && penable && pwrite;

    // Write registers in the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_thr_reg <= cfsm_pkg::OV_THR_RST;
            uv_thr_reg <= cfsm_pkg::UV_THR_RST;
            cpb_reg    <= cfsm_pkg::CPB_RST;
            isl_reg    <= cfsm_pkg::ISL_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                cfsm_pkg::REG_OV_THR: ov_thr_reg <= pwdata[cfsm_pkg::VOLT_W-1:0];
                cfsm_pkg::REG_UV_THR: uv_thr_reg <= pwdata[cfsm_pkg::VOLT_W-1:0];
                cfsm_pkg::REG_CPB:    cpb_reg    <= pwdata[cfsm_pkg::CPB_W-1:0];
                cfsm_pkg::REG_ISL:    isl_reg    <= pwdata[cfsm_pkg::ISL_W-1:0];
                default:              ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        case (reg_idx)
            cfsm_pkg::REG_OV_THR: prdata = cfsm_pkg::APB_DW'(ov_thr_reg);
            cfsm_pkg::REG_UV_THR: prdata = cfsm_pkg::APB_DW'(uv_thr_reg);
            cfsm_pkg::REG_CPB:    prdata = cfsm_pkg::APB_DW'(cpb_reg);
            cfsm_pkg::REG_ISL:    prdata = cfsm_pkg::APB_DW'(isl_reg);
            default:              prdata = '0;
        endcase
    end

    assign cfg.ov_thr = ov_thr_reg;
    assign cfg.uv_thr = uv_thr_reg;
    assign cfg.cpb    = cpb_reg;
    assign cfg.isl    = isl_reg;

endmodule

@@ sv/cfsm_board_cnt.sv @@
// Per-board invalid-reading counters: RAM read-modify-write with forwarding.
module cfsm_board_cnt #(
    parameter int MAX_BOARDS = cfsm_pkg::MAX_BOARDS_DEF
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  cfsm_pkg::cfg_t                                  cfg,
    input  logic                                            rd_en,
    input  logic [((MAX_BOARDS > 1) ? $clog2(MAX_BOARDS) : 1)-1:0] rd_board,
    input  logic                                            hold,
    input  logic                                            upd_en,
    input  logic [((MAX_BOARDS > 1) ? $clog2(MAX_BOARDS) : 1)-1:0] upd_board,
    input  logic                                            upd_invalid,
    output logic                                            comm_fault
);

    localparam int BOARD_W = (MAX_BOARDS > 1) ? $clog2(MAX_BOARDS) : 1;
    localparam int CW      = cfsm_pkg::COUNT_W;

    logic [CW-1:0]         rdata;
    logic [CW-1:0]         cur_cnt;
    logic [CW-1:0]         new_cnt;
    logic [CW-1:0]         limit;
    logic [MAX_BOARDS-1:0] vld_reg;
    logic                  fwd_valid_reg;
    logic [BOARD_W-1:0]    fwd_board_reg;
    logic [CW-1:0]         fwd_cnt_reg;
    logic                  fwd_hit;

    cfsm_ram #(
        .WIDTH (CW),
        .DEPTH (MAX_BOARDS)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (upd_en),
        .waddr (upd_board),
        .wdata (new_cnt),
        .re    (rd_en),
        .raddr (rd_board),
        .rdata (rdata)
    );

    // Pick the freshest count: last write if it missed the read, else RAM, or zero if never written
    assign fwd_hit = fwd_valid_reg && (fwd_board_reg == upd_board);

    always_comb
    begin
        if (fwd_hit)
        begin
            cur_cnt = fwd_cnt_reg;
        end
        else if (vld_reg[upd_board])
        begin
            cur_cnt = rdata;
        end
        else
        begin
            cur_cnt = '0;
        end
    end

    // Count up with saturation on invalid, clear on valid
    always_comb
    begin
        if (!upd_invalid)
        begin
            new_cnt = '0;
        end
        else if (cur_cnt == cfsm_pkg::COUNT_MAX)
        begin
            new_cnt = cur_cnt;
        end
        else
        begin
            new_cnt = cur_cnt + CW'(1);
        end
    end

    assign limit      = CW'(cfg.cpb) * CW'(cfg.isl);
    assign comm_fault = upd_invalid && (new_cnt > limit);

    // Mark entries written since reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (upd_en)
        begin
            vld_reg[upd_board] <= 1'b1;
        end
    end

    // Keep the last write for the item whose read overlapped it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else if (!hold)
        begin
            fwd_valid_reg <= upd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!hold)
        begin
            fwd_board_reg <= upd_board;
            fwd_cnt_reg   <= new_cnt;
        end
    end

endmodule

@@ sv/cell_fault_scan_monitor.sv @@
// Cell fault scan monitor: input item channel, result channel, config port.
//
// One cell record per input item on s_axis (cell_voltage, cell_connected,
// data_valid, over_temp, temp_open); CELLS_PER_SCAN items form one scan.
// After the last cell of a scan one result item leaves on m_axis with the
// fault byte, the any-fault bit and the last offending cell numbers; other
// items produce no result. The user must write thresholds and board sizing
// over the APB-style port while the block is idle; it is not enforced.
// Throughput is one item per cycle unless the check stage stalls. An item is
// registered at acceptance, its board counter is read from the counter RAM in
// the same cycle and updated from the check stage; a write that overlaps the
// next read of the same board is forwarded. The result passes the check stage
// and the output register to m_axis and is held until m_axis_tready.
// While a result waits, items keep being accepted; only the last item of
// the next scan waits in the check stage, and s_axis_tready drops then.
// Reset clears scan position, fault byte, cell numbers and all board
// counters at once (per-board valid bits), and restores register defaults.
`include "cell_fault_scan_monitor_defines.svh"

module cell_fault_scan_monitor #(
    parameter int CELLS_PER_SCAN = cfsm_pkg::CELLS_PER_SCAN_DEF,
    parameter int MAX_BOARDS     = cfsm_pkg::MAX_BOARDS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // Configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cfsm_pkg::APB_AW-1:0] paddr,
    input  logic [cfsm_pkg::APB_DW-1:0] pwdata,
    output logic [cfsm_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    // Input items
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // [15:0] cell_voltage, [16] cell_connected, [17] data_valid,
    // [18] over_temp, [19] temp_open, [23:20] zero
    input  logic [cfsm_pkg::IN_W-1:0]   s_axis_tdata,
    // Result items
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [0] any_fault, [8:1] fault_flags, [15:9] ov_cell, [22:16] uv_cell,
    // [29:23] ot_cell, [36:30] open_wire_cell, [43:37] open_sensor_cell,
    // [47:44] zero
    output logic [cfsm_pkg::OUT_W-1:0]  m_axis_tdata
);

    localparam int BOARD_W = (MAX_BOARDS > 1) ? $clog2(MAX_BOARDS) : 1;
    localparam int CELL_W  = cfsm_pkg::CELL_W;
    localparam int POS_W   = cfsm_pkg::CPB_W;
    localparam int FLAG_W  = cfsm_pkg::FLAG_W;
    localparam int VOLT_W  = cfsm_pkg::VOLT_W;
    localparam logic [BOARD_W-1:0] LAST_BOARD = BOARD_W'(MAX_BOARDS - 1);
    localparam logic [CELL_W-1:0]  LAST_POS   = CELL_W'(CELLS_PER_SCAN - 1);

    cfsm_pkg::cfg_t cfg;

    // Handshake
    logic in_acc;
    logic s1_stall;
    logic s1_done;
    logic out_load;

    // Sequencer
    logic [CELL_W-1:0]  scan_pos_reg;
    logic [CELL_W-1:0]  scan_pos_next;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    logic [BOARD_W-1:0] board_reg;
    logic [BOARD_W-1:0] board_next;
    logic [POS_W:0]     pos_inc;
    logic               in_last;

    // Check stage
    logic               s1_valid_reg;
    logic [VOLT_W-1:0]  s1_volt_reg;
    logic               s1_conn_reg;
    logic               s1_dvalid_reg;
    logic               s1_hot_reg;
    logic               s1_sopen_reg;
    logic [CELL_W-1:0]  s1_cell_reg;
    logic [BOARD_W-1:0] s1_board_reg;
    logic               s1_last_reg;
    logic               comm_fault;
    logic               hit_ov;
    logic               hit_uv;
    logic [FLAG_W-1:0]  item_flags;
    logic [FLAG_W-1:0]  flags_all;

    // Scan state
    logic [FLAG_W-1:0]  run_flags_reg;
    logic [FLAG_W-1:0]  run_flags_next;
    logic [CELL_W-1:0]  ov_cell_reg;
    logic [CELL_W-1:0]  ov_cell_next;
    logic [CELL_W-1:0]  uv_cell_reg;
    logic [CELL_W-1:0]  uv_cell_next;
    logic [CELL_W-1:0]  ot_cell_reg;
    logic [CELL_W-1:0]  ot_cell_next;
    logic [CELL_W-1:0]  ow_cell_reg;
    logic [CELL_W-1:0]  ow_cell_next;
    logic [CELL_W-1:0]  os_cell_reg;
    logic [CELL_W-1:0]  os_cell_next;

    // Output register
    logic               out_valid_reg;
    logic [FLAG_W-1:0]  out_flags_reg;
    logic [CELL_W-1:0]  out_ov_reg;
    logic [CELL_W-1:0]  out_uv_reg;
    logic [CELL_W-1:0]  out_ot_reg;
    logic [CELL_W-1:0]  out_ow_reg;
    logic [CELL_W-1:0]  out_os_reg;

    cfsm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Stall the check stage only when it must emit and the output is full
    assign s1_stall      = s1_valid_reg && s1_last_reg && out_valid_reg && !m_axis_tready;
    assign s1_done       = s1_valid_reg && !s1_stall;
    assign s_axis_tready = !s1_stall;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_load      = s1_done && s1_last_reg;

    // Advance scan, board and position counters on each accepted item
    assign in_last = (scan_pos_reg == LAST_POS);
    assign pos_inc = {1'b0, pos_reg} + (POS_W + 1)'(1);

    always_comb
    begin
        scan_pos_next = scan_pos_reg;
        pos_next      = pos_reg;
        board_next    = board_reg;
        if (in_acc)
        begin
            if (in_last)
            begin
                scan_pos_next = '0;
                pos_next      = '0;
                board_next    = '0;
            end
            else
            begin
                scan_pos_next = scan_pos_reg + CELL_W'(1);
                if (pos_inc >= {1'b0, cfg.cpb})
                begin
                    pos_next = '0;
                    if (board_reg != LAST_BOARD)
                    begin
                        board_next = board_reg + BOARD_W'(1);
                    end
                end
                else
                begin
                    pos_next = pos_inc[POS_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_pos_reg <= '0;
            pos_reg      <= '0;
            board_reg    <= '0;
        end
        else
        begin
            scan_pos_reg <= scan_pos_next;
            pos_reg      <= pos_next;
            board_reg    <= board_next;
        end
    end

    // Capture the item into the check stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_acc || s1_stall;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_volt_reg   <= s_axis_tdata[VOLT_W-1:0];
            s1_conn_reg   <= s_axis_tdata[16];
            s1_dvalid_reg <= s_axis_tdata[17];
            s1_hot_reg    <= s_axis_tdata[18];
            s1_sopen_reg  <= s_axis_tdata[19];
            s1_cell_reg   <= scan_pos_reg + CELL_W'(1);
            s1_board_reg  <= board_reg;
            s1_last_reg   <= in_last;
        end
    end

    cfsm_board_cnt #(
        .MAX_BOARDS (MAX_BOARDS)
    ) u_board_cnt (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .rd_en       (in_acc),
        .rd_board    (board_reg),
        .hold        (s1_stall),
        .upd_en      (s1_done),
        .upd_board   (s1_board_reg),
        .upd_invalid (!s1_dvalid_reg),
        .comm_fault  (comm_fault)
    );

    // Classify the item
    assign hit_ov = s1_volt_reg > cfg.ov_thr;
    assign hit_uv = s1_volt_reg < cfg.uv_thr;

    assign item_flags = (hit_ov        ? cfsm_pkg::FLAG_OV         : '0)
                      | (hit_uv        ? cfsm_pkg::FLAG_UV         : '0)
                      | (s1_hot_reg    ? cfsm_pkg::FLAG_OT         : '0)
                      | (s1_sopen_reg  ? cfsm_pkg::FLAG_TEMP_OPEN  : '0)
                      | (comm_fault    ? cfsm_pkg::FLAG_BOARD_COMM : '0)
                      | (!s1_conn_reg  ? cfsm_pkg::FLAG_CELL_OPEN  : '0);
    assign flags_all = run_flags_reg | item_flags;

    // Update the running fault byte and last offending cells
    always_comb
    begin
        run_flags_next = run_flags_reg;
        ov_cell_next   = ov_cell_reg;
        uv_cell_next   = uv_cell_reg;
        ot_cell_next   = ot_cell_reg;
        ow_cell_next   = ow_cell_reg;
        os_cell_next   = os_cell_reg;
        if (s1_done)
        begin
            run_flags_next = s1_last_reg ? '0 : flags_all;
            if (hit_ov)
            begin
                ov_cell_next = s1_cell_reg;
            end
            if (hit_uv)
            begin
                uv_cell_next = s1_cell_reg;
            end
            if (s1_hot_reg)
            begin
                ot_cell_next = s1_cell_reg;
            end
            if (!s1_conn_reg)
            begin
                ow_cell_next = s1_cell_reg;
            end
            if (s1_sopen_reg)
            begin
                os_cell_next = s1_cell_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_flags_reg <= '0;
            ov_cell_reg   <= '0;
            uv_cell_reg   <= '0;
            ot_cell_reg   <= '0;
            ow_cell_reg   <= '0;
            os_cell_reg   <= '0;
        end
        else
        begin
            run_flags_reg <= run_flags_next;
            ov_cell_reg   <= ov_cell_next;
            uv_cell_reg   <= uv_cell_next;
            ot_cell_reg   <= ot_cell_next;
            ow_cell_reg   <= ow_cell_next;
            os_cell_reg   <= os_cell_next;
        end
    end

    // Hold the scan result until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_load || (out_valid_reg && !m_axis_tready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_flags_reg <= flags_all;
            out_ov_reg    <= ov_cell_next;
            out_uv_reg    <= uv_cell_next;
            out_ot_reg    <= ot_cell_next;
            out_ow_reg    <= ow_cell_next;
            out_os_reg    <= os_cell_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_os_reg, out_ow_reg, out_ot_reg, out_uv_reg,
                            out_ov_reg, out_flags_reg, |out_flags_reg};

    // Checks
    `CFSM_ASSERT_NOW(a_load_into_free_output, out_load, !out_valid_reg || m_axis_tready)
    `CFSM_ASSERT_NOW(a_ready_low_only_when_blocked, !s_axis_tready,
                     s1_valid_reg && s1_last_reg && out_valid_reg)
    `CFSM_ASSERT_NEXT(a_scan_wraps_after_last, in_acc && in_last,
                      scan_pos_reg == '0 && pos_reg == '0 && board_reg == '0)
    `CFSM_ASSERT_NOW(a_reserved_flag_bits_zero, out_valid_reg,
                     out_flags_reg[3] == 1'b0 && out_flags_reg[6] == 1'b0)

endmodule

@@ test/cell_fault_scan_monitor_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the cell fault scan monitor: directed and random scans.
module cell_fault_scan_monitor_tb;
    import cfsm_pkg::*;

    localparam int SCAN_CELLS  = CELLS_PER_SCAN_DEF;
    localparam int BOARDS      = MAX_BOARDS_DEF;
    localparam int PIPE_SETTLE = 6;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 3000;
    localparam int MAX_REPORTS = 10;
    localparam int NONE        = -1;

    // One cell record, laid out as on s_axis_tdata[19:0]
    typedef struct packed {
        logic              sensor_open;
        logic              hot;
        logic              valid;
        logic              connected;
        logic [VOLT_W-1:0] volt;
    } cell_t;

    // One scan report, laid out as on m_axis_tdata[43:0]
    typedef struct packed {
        logic [CELL_W-1:0] open_sensor;
        logic [CELL_W-1:0] open_wire;
        logic [CELL_W-1:0] ot;
        logic [CELL_W-1:0] uv;
        logic [CELL_W-1:0] ov;
        logic [FLAG_W-1:0] flags;
        logic              any;
    } scan_result_t;

    typedef enum {CELL_NOMINAL, CELL_FAULTY, CELL_NOISE} cell_kind_e;

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              psel          = 1'b0;
    logic              penable       = 1'b0;
    logic              pwrite        = 1'b0;
    logic [APB_AW-1:0] paddr         = '0;
    logic [APB_DW-1:0] pwdata        = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata  = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;

    // Predictor copy of the registers and scan state
    logic [VOLT_W-1:0]  ov_thr           = OV_THR_RST;
    logic [VOLT_W-1:0]  uv_thr           = UV_THR_RST;
    logic [CPB_W-1:0]   cpb              = CPB_RST;
    logic [ISL_W-1:0]   isl              = ISL_RST;
    logic [CELL_W-1:0]  scan_pos         = '0;
    logic [CPB_W-1:0]   board_pos        = '0;
    logic [3:0]         board_idx        = '0;
    logic [FLAG_W-1:0]  scan_flags       = '0;
    logic [CELL_W-1:0]  last_ov          = '0;
    logic [CELL_W-1:0]  last_uv          = '0;
    logic [CELL_W-1:0]  last_ot          = '0;
    logic [CELL_W-1:0]  last_open_wire   = '0;
    logic [CELL_W-1:0]  last_open_sensor = '0;
    logic [COUNT_W-1:0] invalid_count [BOARDS] = '{default: '0};

    scan_result_t expected_scans [$];

    int error_count    = 0;
    int cells_sent     = 0;
    int results_seen   = 0;
    int reg_writes     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int idle_cycles    = 0;

    cell_fault_scan_monitor u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 clk = ~clk;

    // Fold one cell into the scan state; return 1 with the report on the last cell
    function automatic bit tally_cell(input cell_t c, output scan_result_t res);
        logic [CELL_W-1:0] num;
        int                limit;
        num   = scan_pos + 1'b1;
        limit = int'(cpb) * int'(isl);
        res   = '0;
        if (c.volt > ov_thr) begin
            scan_flags |= FLAG_OV;
            last_ov = num;
        end
        if (c.volt < uv_thr) begin
            scan_flags |= FLAG_UV;
            last_uv = num;
        end
        if (!c.connected) begin
            scan_flags |= FLAG_CELL_OPEN;
            last_open_wire = num;
        end
        if (c.hot) begin
            scan_flags |= FLAG_OT;
            last_ot = num;
        end
        if (c.sensor_open) begin
            scan_flags |= FLAG_TEMP_OPEN;
            last_open_sensor = num;
        end
        // count invalid readings per board, saturating; a valid one clears
        if (!c.valid) begin
            if (invalid_count[board_idx] != COUNT_MAX)
                invalid_count[board_idx] += 1'b1;
            if (int'(invalid_count[board_idx]) > limit)
                scan_flags |= FLAG_BOARD_COMM;
        end
        else
            invalid_count[board_idx] = '0;
        // advance the board; surplus cells stay on the last board
        if (int'(board_pos) + 1 >= int'(cpb)) begin
            board_pos = '0;
            if (int'(board_idx) < BOARDS - 1)
                board_idx += 1'b1;
        end
        else
            board_pos += 1'b1;
        if (int'(scan_pos) + 1 >= SCAN_CELLS) begin
            res.any         = (scan_flags != '0);
            res.flags       = scan_flags;
            res.ov          = last_ov;
            res.uv          = last_uv;
            res.ot          = last_ot;
            res.open_wire   = last_open_wire;
            res.open_sensor = last_open_sensor;
            scan_flags = '0;
            scan_pos   = '0;
            board_pos  = '0;
            board_idx  = '0;
            return 1'b1;
        end
        scan_pos += 1'b1;
        return 1'b0;
    endfunction

    function automatic cell_t make_cell(input cell_kind_e kind);
        cell_t c;
        c             = '0;
        c.connected   = 1'b1;
        c.valid       = 1'b1;
        c.volt        = $urandom_range(ov_thr, uv_thr);
        if (kind == CELL_NOISE)
            c = $urandom;
        else if (kind == CELL_FAULTY) begin
            case ($urandom_range(9))
                0: c.volt = ov_thr + 1'b1;
                1: c.volt = ov_thr;
                2: c.volt = uv_thr - 1'b1;
                3: c.volt = uv_thr;
                4: c.volt = $urandom;
                5: c.connected = 1'b0;
                6: c.hot = 1'b1;
                7: c.sensor_open = 1'b1;
                8: c.valid = 1'b0;
                default: c = $urandom;
            endcase
        end
        return c;
    endfunction

    task automatic note_failure(input string what);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%0t ns: %s", $time, what);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
            note_failure($sformatf("scan %0d %s: expected %0d, got %0d",
                                   results_seen, name, want, got));
    endtask

    // Offer one cell after a random gap; predict at acceptance
    task automatic send_cell(input cell_t c);
        scan_result_t res;
        logic         ready_seen;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tdata  <= IN_W'(c);
        s_axis_tvalid <= 1'b1;
        do begin
            @(negedge clk);
            ready_seen = s_axis_tready;
            @(posedge clk);
        end while (!ready_seen);
        if (tally_cell(c, res))
            expected_scans.push_back(res);
        cells_sent++;
    endtask

    // Hold the input until every report is back, then let the pipeline settle
    task automatic drain_results(input int pause);
        s_axis_tvalid <= 1'b0;
        while (expected_scans.size() != 0)
            @(posedge clk);
        repeat (pause) @(posedge clk);
    endtask

    task automatic write_reg(input logic [REG_IW-1:0] idx, input logic [APB_DW-1:0] value);
        logic ready_seen;
        drain_results(PIPE_SETTLE);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do begin
            @(negedge clk);
            ready_seen = pready;
            @(posedge clk);
        end while (!ready_seen);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_OV_THR: ov_thr = value[VOLT_W-1:0];
            REG_UV_THR: uv_thr = value[VOLT_W-1:0];
            REG_CPB:    cpb    = value[CPB_W-1:0];
            REG_ISL:    isl    = value[ISL_W-1:0];
            default:    ;
        endcase
        reg_writes++;
    endtask

    // Send cells until the current scan ends; invalid readings in [lo, hi],
    // an optional board resize before position resize_at
    task automatic random_scan(input int fault_pct, input int noise_pct,
                               input int lo, input int hi,
                               input int resize_at, input int resize_to);
        cell_t      c;
        cell_kind_e kind;
        int         r;
        do begin
            if (int'(scan_pos) == resize_at)
                write_reg(REG_CPB, resize_to);
            r = $urandom_range(99);
            if (r < noise_pct)
                kind = CELL_NOISE;
            else if (r < noise_pct + fault_pct)
                kind = CELL_FAULTY;
            else
                kind = CELL_NOMINAL;
            c = make_cell(kind);
            if (int'(scan_pos) >= lo && int'(scan_pos) <= hi)
                c.valid = 1'b0;
            send_cell(c);
        end while (scan_pos != '0);
    endtask

    task automatic shuffle_config();
        write_reg(REG_OV_THR, ($urandom_range(7) == 0) ? 16'hFFFF * $urandom_range(1)
                                                       : $urandom_range(38000, 46000));
        write_reg(REG_UV_THR, ($urandom_range(7) == 0) ? 16'hFFFF * $urandom_range(1)
                                                       : $urandom_range(26000, 34000));
        write_reg(REG_CPB, ($urandom_range(7) == 0) ? $urandom_range(15)
                                                    : $urandom_range(6, 12));
        write_reg(REG_ISL, ($urandom_range(3) == 0) ? $urandom_range(31)
                                                    : $urandom_range(4));
    endtask

    // Default registers: threshold edges, each fault kind, fault on the last cell
    task automatic test_default_scan();
        cell_t             c;
        logic [VOLT_W-1:0] probe_volts [6];
        probe_volts = '{16'd0, 16'hFFFF, OV_THR_RST, OV_THR_RST + 1'b1,
                        UV_THR_RST, UV_THR_RST - 1'b1};
        foreach (probe_volts[i]) begin
            c = make_cell(CELL_NOMINAL);
            c.volt = probe_volts[i];
            send_cell(c);
        end
        c = make_cell(CELL_NOMINAL);
        c.connected = 1'b0;
        send_cell(c);
        c = make_cell(CELL_NOMINAL);
        c.hot = 1'b1;
        send_cell(c);
        c = make_cell(CELL_NOMINAL);
        c.sensor_open = 1'b1;
        send_cell(c);
        c = make_cell(CELL_NOMINAL);
        c.valid = 1'b0;
        send_cell(c);
        send_cell('0);
        send_cell('1);
        while (int'(scan_pos) != SCAN_CELLS - 1)
            send_cell(make_cell(CELL_NOMINAL));
        c = make_cell(CELL_NOMINAL);
        c.volt = '1;
        c.hot  = 1'b1;
        send_cell(c);
        // clean scan: no flags, cell numbers kept
        random_scan(0, 0, NONE, NONE, NONE, 0);
    endtask

    task automatic test_threshold_extremes();
        cell_t c;
        write_reg(REG_OV_THR, 0);
        write_reg(REG_UV_THR, 16'hFFFF);
        c = make_cell(CELL_NOMINAL);
        c.volt = 16'd0;
        send_cell(c);
        c.volt = 16'd1;
        send_cell(c);
        c.volt = 16'hFFFF;
        send_cell(c);
        random_scan(30, 10, NONE, NONE, NONE, 0);
        write_reg(REG_OV_THR, 16'hFFFF);
        write_reg(REG_UV_THR, 0);
        c.volt = 16'd0;
        send_cell(c);
        c.volt = 16'hFFFF;
        send_cell(c);
        random_scan(0, 0, NONE, NONE, NONE, 0);
        write_reg(REG_OV_THR, OV_THR_RST);
        write_reg(REG_UV_THR, UV_THR_RST);
    endtask

    // Limit zero, a large limit, zero and largest board sizes
    task automatic test_invalid_limit();
        write_reg(REG_CPB, 6);
        write_reg(REG_ISL, 0);
        random_scan(0, 0, 7, 7, NONE, 0);
        write_reg(REG_CPB, 12);
        write_reg(REG_ISL, 31);
        random_scan(0, 0, 0, 40, NONE, 0);
        write_reg(REG_CPB, 0);
        write_reg(REG_ISL, 5);
        random_scan(10, 0, 20, 20, NONE, 0);
        write_reg(REG_CPB, 15);
        random_scan(10, 10, NONE, NONE, NONE, 0);
    endtask

    // Shrink the board below the current position, then grow it, mid-scan
    task automatic test_board_resize();
        write_reg(REG_ISL, 1);
        write_reg(REG_CPB, 12);
        random_scan(0, 0, 0, SCAN_CELLS - 1, 10, 6);
        random_scan(0, 0, 0, SCAN_CELLS - 1, 3, 12);
        random_scan(0, 0, NONE, NONE, NONE, 0);
    endtask

    // Drive the last board's counter past its top; a wrapping counter would
    // miss the board fault in the final scan
    task automatic test_counter_saturation();
        write_reg(REG_ISL, 31);
        write_reg(REG_CPB, 1);
        random_scan(0, 0, NONE, NONE, NONE, 0);
        repeat (6) random_scan(0, 0, 0, SCAN_CELLS - 1, NONE, 0);
        write_reg(REG_CPB, 2);
        random_scan(0, 0, 30, SCAN_CELLS - 1, NONE, 0);
        write_reg(REG_CPB, 6);
        random_scan(0, 0, 90, SCAN_CELLS - 1, NONE, 0);
    endtask

    // Hold off the result side long enough for the input to stall
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        drain_results(PIPE_SETTLE);
        @(negedge clk);
        hold_requests++;
        @(posedge clk);
        repeat (2) random_scan(20, 10, NONE, NONE, NONE, 0);
        // pause the sender until every report is back
        drain_results(PIPE_SETTLE);
        random_scan(20, 10, NONE, NONE, NONE, 0);
    endtask

    task automatic test_random_traffic();
        int idle_mix [4][2];
        int lo;
        int hi;
        int resize_at;
        idle_mix = '{'{0, 0}, '{57, 0}, '{0, 57}, '{31, 31}};
        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = idle_mix[phase][0];
            recv_stall_pct = idle_mix[phase][1];
            for (int s = 0; s < 9; s++) begin
                if ($urandom_range(3) == 0)
                    shuffle_config();
                lo = NONE;
                hi = NONE;
                if ($urandom_range(2) == 0) begin
                    lo = $urandom_range(SCAN_CELLS - 1);
                    hi = lo + $urandom_range(30);
                end
                resize_at = ($urandom_range(7) == 0) ? $urandom_range(1, SCAN_CELLS - 2)
                                                     : NONE;
                random_scan($urandom_range(2, 25), ($urandom_range(4) == 0) ? 100 : 5,
                            lo, hi, resize_at, $urandom_range(15));
            end
        end
    endtask

    // Result side: random stalls, or a long hold-off on request
    always @(posedge clk) begin
        if (hold_seen != hold_requests) begin
            hold_seen     <= hold_requests;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare each accepted report with the oldest prediction
    always @(negedge clk) begin
        scan_result_t got;
        scan_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            got = scan_result_t'(m_axis_tdata[$bits(scan_result_t)-1:0]);
            results_seen++;
            if (expected_scans.size() == 0)
                note_failure($sformatf("unexpected report, flags %02h", got.flags));
            else begin
                want = expected_scans.pop_front();
                check_field("any_fault", want.any, got.any);
                check_field("fault_flags", want.flags, got.flags);
                check_field("ov_cell", want.ov, got.ov);
                check_field("uv_cell", want.uv, got.uv);
                check_field("ot_cell", want.ot, got.ot);
                check_field("open_wire_cell", want.open_wire, got.open_wire);
                check_field("open_sensor_cell", want.open_sensor, got.open_sensor);
            end
        end
    end

    // Stop the run when nothing moves for too long
    always @(negedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_scan();
        test_threshold_extremes();
        test_invalid_limit();
        test_board_resize();
        test_counter_saturation();
        test_backpressure();
        test_random_traffic();
        drain_results(PIPE_SETTLE + 4);
        $display("Sent %0d cells, checked %0d scan reports, %0d register writes.",
                 cells_sent, results_seen, reg_writes);
        $display("Threshold and board-size extremes, saturation, resize and stalls covered.");
        if (error_count == 0 && expected_scans.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+sv
sv/cfsm_pkg.sv
sv/cfsm_ram.sv
sv/cfsm_cfg.sv
sv/cfsm_board_cnt.sv
sv/cell_fault_scan_monitor.sv
test/cell_fault_scan_monitor_tb.sv
